// ----- rtl/core/ccpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpc_pkg
// Shared types and constants of the character-cell priority compositor.
// ----------------------------------------------------------------------------
package ccpc_pkg;

  // One stored cell: character, color attribute, priority.
  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] attr;
    logic [15:0] prio;
  } cell_t;

  // Transaction opcodes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CLEAR_ATTR    = 2'd2;

  localparam logic [7:0]  CLEAR_CHAR = 8'd35;     // '#'
  localparam logic [7:0]  NEWLINE    = 8'd10;
  localparam logic [7:0]  NUL_CHAR   = 8'd0;
  localparam logic [15:0] CLEAR_PRIO = 16'hFFFF;  // -1
  localparam logic [9:0]  CURSOR_MAX = 10'd1023;

endpackage

// ----- rtl/core/ccpc_cell_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpc_cell_ram
// Single-port-write, single-port-read cell memory with registered read data.
// ----------------------------------------------------------------------------
module ccpc_cell_ram
  import ccpc_pkg::*;
#(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output cell_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cell_t         wr_data
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/char_cell_priority_compositor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_cell_priority_compositor_top
// Character-cell frame store with a per-cell priority test.
// ----------------------------------------------------------------------------
// All cells live in one synchronous memory (MAX_ROWS rows of 2**ceil(log2
// MAX_COLS) words, at least two rows), with registered read data. A begin
// or newline transaction, a zero byte, and a character that falls off
// screen leave the sequencer idle. A drawn character passes through the
// write state: the cell is read, its priority compared, and the cell
// written back unless its stored priority is greater. A read passes through
// the read state to the output register, which it enters once that register
// is free; the register holds the result until it is taken while the next
// transaction is already accepted. A clear sweeps one memory word per
// cycle; the same sweep runs right after reset, and no transaction is
// accepted until it ends. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module char_cell_priority_compositor_top
  import ccpc_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [7:0]         char_code,
  input  logic signed [9:0]  origin_x,
  input  logic signed [9:0]  origin_y,
  input  logic [15:0]        color,
  input  logic signed [15:0] priority_req,
  input  logic [6:0]         read_col,
  input  logic [5:0]         read_row,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         cell_char,
  output logic [15:0]        cell_attr,
  output logic signed [15:0] cell_priority
);

  localparam int CW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROWS_ALLOC = (MAX_ROWS > 1) ? MAX_ROWS : 2;
  localparam int DEPTH      = ROWS_ALLOC << CW;
  localparam int AW         = RW + CW;
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [8:0]    MAX_COLS_W = 9'(MAX_COLS);
  localparam logic [8:0]    MAX_ROWS_W = 9'(MAX_ROWS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR   = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  // configuration registers
  logic [7:0]  screen_width;
  logic [6:0]  screen_height;
  logic [15:0] clear_attr;

  // text state
  logic signed [9:0]  text_origin_x;
  logic signed [9:0]  text_origin_y;
  logic [15:0]        text_color;
  logic signed [15:0] text_priority;
  logic [9:0]         cursor_line;
  logic [9:0]         cursor_column;

  logic [1:0]    state;
  logic [AW-1:0] sweep_addr;
  logic [15:0]   sweep_attr;
  logic [AW-1:0] draw_addr;
  logic [7:0]    draw_char;
  logic          read_oob;

  logic          accept;
  logic [11:0]   draw_x;
  logic [11:0]   draw_y;
  logic [8:0]    width_eff;
  logic [8:0]    height_eff;
  logic          on_screen;
  logic          is_glyph;
  logic          in_store;
  logic [7:0]    col_ext;
  logic [7:0]    row_ext;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] req_addr;
  logic          out_load;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  cell_t         ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cell_t         ram_wdata;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // cursor position on screen
  assign draw_x     = {{2{text_origin_x[9]}}, text_origin_x} + {2'b00, cursor_column};
  assign draw_y     = {{2{text_origin_y[9]}}, text_origin_y} + {2'b00, cursor_line};
  assign width_eff  = ({1'b0, screen_width} < MAX_COLS_W) ? {1'b0, screen_width} : MAX_COLS_W;
  assign height_eff = ({2'b00, screen_height} < MAX_ROWS_W) ? {2'b00, screen_height}
                                                            : MAX_ROWS_W;
  assign on_screen  = !draw_x[11] && (draw_x[10:0] < {2'b00, width_eff}) &&
                      !draw_y[11] && (draw_y[10:0] < {2'b00, height_eff});
  assign is_glyph   = (char_code != NUL_CHAR) && (char_code != NEWLINE);
  assign cur_addr   = {draw_y[RW-1:0], draw_x[CW-1:0]};

  // read address
  assign col_ext  = {1'b0, read_col};
  assign row_ext  = {2'b00, read_row};
  assign in_store = ({2'b00, read_col} < MAX_COLS_W) && ({3'b000, read_row} < MAX_ROWS_W);
  assign req_addr = {row_ext[RW-1:0], col_ext[CW-1:0]};

  // memory read port
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cur_addr;
    if (accept && op == OP_CHAR && is_glyph && on_screen) begin
      ram_re = 1'b1;
    end else if (accept && op == OP_READ) begin
      ram_re    = 1'b1;
      ram_raddr = req_addr;
    end
  end

  // memory write port: sweep or priority-tested draw
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_addr;
    ram_wdata = '{ch: CLEAR_CHAR, attr: sweep_attr, prio: CLEAR_PRIO};
    case (state)
      ST_CLR: begin
        ram_we = 1'b1;
      end
      ST_WR: begin
        ram_waddr = draw_addr;
        ram_wdata = '{ch: draw_char, attr: text_color, prio: text_priority};
        ram_we    = !($signed(ram_rdata.prio) > text_priority);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ccpc_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_ram (
    .clk     (clk),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 8'd128;
      screen_height <= 7'd64;
      clear_attr    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[7:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[6:0];
        REG_CLEAR_ATTR:    clear_attr    <= cfg_data;
        default:           ;
      endcase
    end
  end

  // text state and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      text_origin_x <= '0;
      text_origin_y <= '0;
      text_color    <= '0;
      text_priority <= '0;
      cursor_line   <= '0;
      cursor_column <= '0;
    end else if (accept && op == OP_BEGIN) begin
      text_origin_x <= origin_x;
      text_origin_y <= origin_y;
      text_color    <= color;
      text_priority <= priority_req;
      cursor_line   <= '0;
      cursor_column <= '0;
    end else if (accept && op == OP_CHAR && char_code == NEWLINE) begin
      if (cursor_line != CURSOR_MAX) begin
        cursor_line <= cursor_line + 10'd1;
      end
      cursor_column <= '0;
    end else if (accept && op == OP_CHAR && is_glyph) begin
      if (cursor_column != CURSOR_MAX) begin
        cursor_column <= cursor_column + 10'd1;
      end
    end
  end

  assign out_load = (state == ST_RD) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      sweep_addr <= '0;
      sweep_attr <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_CHAR: begin
                if (is_glyph && on_screen) begin
                  state <= ST_WR;
                end
              end
              OP_CLEAR: begin
                state      <= ST_CLR;
                sweep_addr <= '0;
                sweep_attr <= clear_attr;
              end
              OP_READ: begin
                state <= ST_RD;
              end
              default: ;
            endcase
          end
        end
        ST_WR: begin
          state <= ST_IDLE;
        end
        ST_RD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_CLR: begin
          if (sweep_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // latch per-transaction details
  always_ff @(posedge clk) begin
    if (accept) begin
      draw_addr <= cur_addr;
      draw_char <= char_code;
      read_oob  <= !in_store;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (read_oob) begin
        cell_char     <= CLEAR_CHAR;
        cell_attr     <= clear_attr;
        cell_priority <= CLEAR_PRIO;
      end else begin
        cell_char     <= ram_rdata.ch;
        cell_attr     <= ram_rdata.attr;
        cell_priority <= ram_rdata.prio;
      end
    end
  end

  // checks
  a_no_write_idle : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("memory written while idle");

  a_read_to_rd : assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_READ) |=> (state == ST_RD))
    else $error("read transaction did not enter read state");

  a_clear_start : assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_CLEAR) |=> (state == ST_CLR && sweep_addr == '0))
    else $error("clear sweep did not start at address zero");

  a_prio_test : assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR && ram_we) |-> !($signed(ram_rdata.prio) > text_priority))
    else $error("draw overwrote a cell of greater priority");

endmodule
